@@ rtl/ctaphid_message_reassembler_macros.svh @@
// Assertion macros used by the reassembler checker
`ifndef CTAPHID_MESSAGE_REASSEMBLER_MACROS_SVH
`define CTAPHID_MESSAGE_REASSEMBLER_MACROS_SVH

// Property checked on every rising edge, held off while reset is asserted
`define CTMR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising edge, held off while reset is asserted
`define CTMR_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

@@ rtl/ctmr_pkg.sv @@
// Types and constants of the CTAPHID message reassembler
package ctmr_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_LONG = 2'd1,
    ERR_INIT_MID = 2'd2,
    ERR_SEQ      = 2'd3
  } err_e;

  // configuration register indexes
  localparam logic REG_CHANNEL_ID  = 1'b0;
  localparam logic REG_MAX_MESSAGE = 1'b1;

  localparam logic [31:0] CHANNEL_ID_RST  = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_MESSAGE_RST = 16'd7609;

  localparam int unsigned POS_W   = 7;
  localparam logic [6:0]  POS_MAX = 7'h7F;
  localparam logic [7:0]  INIT_FLAG = 8'h80;
  localparam logic [7:0]  SEQ_MASK  = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] command;
    logic       last;
    err_e       error_code;
  } result_t;

endpackage

@@ rtl/ctmr_in_stage.sv @@
// Input register stage of the reassembler
module ctmr_in_stage
  import ctmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_frame_i,
  output logic       in_stall_o,
  input  logic       take_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  // the held item only blocks when the next stage cannot take it
  assign in_stall_o = valid_q && !take_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q.data_byte      <= data_byte_i;
      item_q.first_of_frame <= first_of_frame_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/ctmr_core.sv @@
// Frame parser and message state of the reassembler
module ctmr_core
  import ctmr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  item_t       item_i,
  input  logic [31:0] channel_id_i,
  input  logic [15:0] max_message_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int unsigned TAKE_W = $clog2(FRAME_BYTES - 4);
  localparam logic [POS_W-1:0]  FRAME_END = POS_W'(FRAME_BYTES);
  localparam logic [15:0]       CAP_CONT  = 16'(FRAME_BYTES - 5);
  localparam logic [15:0]       CAP_INIT  = 16'(FRAME_BYTES - 7);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              match_q, match_d;
  logic              recv_q, recv_d;
  logic              discard_q, discard_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       rcvd_q, rcvd_d;
  logic [6:0]        seq_q, seq_d;
  logic [TAKE_W-1:0] take_q, take_d;

  logic [POS_W-1:0]  p;
  logic [7:0]        b;
  logic              byte_eq;
  logic [15:0]       rem;
  logic [15:0]       new_len;
  logic [15:0]       rcvd_inc;

  always_comb begin
    b        = item_i.data_byte;
    p        = item_i.first_of_frame ? '0 : pos_q;
    byte_eq  = (b == channel_id_i[8*p[1:0] +: 8]);
    rem      = len_q - rcvd_q;
    new_len  = {len_hi_q, b};
    rcvd_inc = rcvd_q + 16'd1;

    pos_d     = (p < POS_MAX) ? p + POS_W'(1) : POS_MAX;
    match_d   = match_q;
    recv_d    = recv_q;
    discard_d = item_i.first_of_frame ? 1'b0 : discard_q;
    take_d    = item_i.first_of_frame ? '0 : take_q;
    cmd_d     = cmd_q;
    len_hi_d  = len_hi_q;
    len_d     = len_q;
    rcvd_d    = rcvd_q;
    seq_d     = seq_q;

    res_valid_o        = 1'b0;
    res_o.kind         = KIND_PAYLOAD;
    res_o.payload_byte = 8'd0;
    res_o.command      = cmd_q;
    res_o.last         = 1'b0;
    res_o.error_code   = ERR_NONE;

    if (!discard_d && p < FRAME_END) begin
      if (p < POS_W'(4)) begin
        match_d = (p == '0) ? byte_eq : (match_q && byte_eq);
      end else if (p == POS_W'(4)) begin
        if (!match_q) begin
          discard_d = 1'b1;
        end else if (!recv_q) begin
          if ((b & INIT_FLAG) == 8'd0) begin
            discard_d = 1'b1;
          end else begin
            cmd_d = b;
          end
        end else if ((b & INIT_FLAG) != 8'd0 || (b & SEQ_MASK) != {1'b0, seq_q}) begin
          // init packet mid-message or sequence slip: abandon the message
          recv_d           = 1'b0;
          discard_d        = 1'b1;
          take_d           = '0;
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ((b & INIT_FLAG) != 8'd0) ? ERR_INIT_MID : ERR_SEQ;
        end else begin
          seq_d  = seq_q + 7'd1;
          take_d = (rem < CAP_CONT) ? rem[TAKE_W-1:0] : CAP_CONT[TAKE_W-1:0];
        end
      end else if (!recv_q) begin
        if (p == POS_W'(5)) begin
          len_hi_d = b;
        end else if (p == POS_W'(6)) begin
          len_d     = new_len;
          discard_d = 1'b1;
          if (new_len > max_message_i) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_TOO_LONG;
          end else if (new_len == 16'd0) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_EMPTY;
          end else begin
            take_d    = (new_len < CAP_INIT) ? new_len[TAKE_W-1:0] : CAP_INIT[TAKE_W-1:0];
            discard_d = 1'b0;
            recv_d    = 1'b1;
            rcvd_d    = 16'd0;
            seq_d     = 7'd0;
          end
        end
      end else if (take_d != '0) begin
        take_d             = take_d - TAKE_W'(1);
        rcvd_d             = rcvd_inc;
        res_valid_o        = 1'b1;
        res_o.payload_byte = b;
        if (rcvd_inc >= len_q) begin
          res_o.last = 1'b1;
          recv_d     = 1'b0;
          discard_d  = 1'b1;
          take_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      match_q   <= 1'b0;
      recv_q    <= 1'b0;
      discard_q <= 1'b1;
      cmd_q     <= 8'd0;
      len_hi_q  <= 8'd0;
      len_q     <= 16'd0;
      rcvd_q    <= 16'd0;
      seq_q     <= 7'd0;
      take_q    <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      match_q   <= match_d;
      recv_q    <= recv_d;
      discard_q <= discard_d;
      cmd_q     <= cmd_d;
      len_hi_q  <= len_hi_d;
      len_q     <= len_d;
      rcvd_q    <= rcvd_d;
      seq_q     <= seq_d;
      take_q    <= take_d;
    end
  end

endmodule

@@ rtl/ctmr_out_stage.sv @@
// Result register stage of the reassembler
module ctmr_out_stage
  import ctmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       res_valid_i,
  input  result_t    res_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] command_o,
  output logic       last_o,
  output logic [1:0] error_code_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= step_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = res_q.kind;
  assign payload_byte_o = res_q.payload_byte;
  assign command_o      = res_q.command;
  assign last_o         = res_q.last;
  assign error_code_o   = res_q.error_code;

endmodule

@@ rtl/ctaphid_message_reassembler.sv @@
// Top level of the CTAPHID message reassembler
// Input channel: one report byte per item (data_byte_i, first_of_frame_i) under
// in_valid_i / in_stall_o. first_of_frame_i marks byte 0 of each report.
// Output channel: at most one result per byte (kind_o, payload_byte_o, command_o,
// last_o, error_code_o) under out_valid_o / out_stall_i.
// Configuration: cfg_we_i writes cfg_data_i to the register picked by cfg_index_i
// (0 channel id, 1 maximum message length); write only while the block is idle.
// Path: a taken byte waits in the input register, is parsed when the result register
// can take it, and its result is then held in the result register.
// Throughput: one byte per cycle unless the result is stalled; the parser and
// message state logic sit between the two registers.
// Reset: pipeline empty, parser idle and discarding until the next report start,
// channel id all ones, maximum length 7609.
// A stalled result holds the result register; one more byte may sit in the input
// register behind it, after which in_stall_o rises until the result is taken.
module ctaphid_message_reassembler
  import ctmr_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  command_o,
  output logic        last_o,
  output logic [1:0]  error_code_o
);

  logic [31:0] channel_id_q;
  logic [15:0] max_message_q;

  logic    item_valid;
  item_t   item;
  logic    out_ready;
  logic    step;
  logic    res_valid;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_id_q  <= CHANNEL_ID_RST;
      max_message_q <= MAX_MESSAGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHANNEL_ID:  channel_id_q  <= cfg_data_i;
        REG_MAX_MESSAGE: max_message_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign step = item_valid && out_ready;

  ctmr_in_stage u_in_stage (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .data_byte_i,
    .first_of_frame_i,
    .in_stall_o,
    .take_i       (out_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ctmr_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk_i,
    .rst_ni,
    .step_i        (step),
    .item_i        (item),
    .channel_id_i  (channel_id_q),
    .max_message_i (max_message_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ctmr_out_stage u_out_stage (
    .clk_i,
    .rst_ni,
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .payload_byte_o,
    .command_o,
    .last_o,
    .error_code_o
  );

endmodule

@@ rtl/ctmr_checker.sv @@
// Port checker for the reassembler and its bind
`include "ctaphid_message_reassembler_macros.svh"

module ctmr_checker
  import ctmr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [7:0]  command_o,
  input logic        last_o,
  input logic [1:0]  error_code_o
);

  // a stalled result keeps its place and its contents
  `CTMR_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    ##1 (out_valid_o && $stable(kind_o) && $stable(payload_byte_o) && $stable(command_o)
         && $stable(last_o) && $stable(error_code_o)),
    "stalled result changed")

  // the input side only waits behind a blocked result
  `CTMR_ASSERT_IMPL(a_in_stall_cause, clk_i, rst_ni, in_stall_o,
    out_valid_o && out_stall_i, "input stalled while the result side is free")

  `CTMR_ASSERT_IMPL(a_kind_known, clk_i, rst_ni, out_valid_o,
    kind_o == KIND_PAYLOAD || kind_o == KIND_EMPTY || kind_o == KIND_ERROR,
    "undefined result kind")

  // only payload items carry a byte or the end-of-message mark
  `CTMR_ASSERT_IMPL(a_nonpayload_clean, clk_i, rst_ni, out_valid_o && kind_o != KIND_PAYLOAD,
    payload_byte_o == 8'd0 && last_o == 1'b0, "byte or last on non-payload item")

  `CTMR_ASSERT_IMPL(a_err_code, clk_i, rst_ni, out_valid_o,
    (kind_o == KIND_ERROR) == (error_code_o != ERR_NONE), "error code does not match kind")

endmodule

bind ctaphid_message_reassembler ctmr_checker u_ctmr_checker (.*);
